// File: design/utf8_to_cp1252_decoder_assert.svh
// Assertion macros shared by the UTF-8 to Windows-1252 decoder RTL.
// Expects clk and rst in the including scope.
`ifndef UTF8_TO_CP1252_DECODER_ASSERT_SVH
`define UTF8_TO_CP1252_DECODER_ASSERT_SVH

// same-cycle implication
`define U2C_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define U2C_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: design/u2c_pkg.sv
// Package for the UTF-8 to Windows-1252 decoder: result type, code point
// widths and the table of Windows-1252 extras. No dependencies.
package u2c_pkg;

  localparam int CP_W      = 21;
  localparam int EXTRA_NUM = 27;

  localparam logic [7:0] QMARK = 8'h3F;

  localparam logic [7:0] LEAD4 = 8'hF0;
  localparam logic [7:0] LEAD3 = 8'hE0;
  localparam logic [7:0] LEAD2 = 8'hC0;

  typedef struct packed {
    logic [7:0] code;
    logic       replaced;
  } u2c_result_t;

  localparam logic [15:0] EXTRA_CP [EXTRA_NUM] = '{
    16'h20AC, 16'h201A, 16'h0192, 16'h201E, 16'h2026, 16'h2020, 16'h2021,
    16'h02C6, 16'h2030, 16'h0160, 16'h2039, 16'h0152, 16'h017D, 16'h2018,
    16'h2019, 16'h201C, 16'h201D, 16'h2022, 16'h2013, 16'h2014, 16'h02DC,
    16'h2122, 16'h0161, 16'h203A, 16'h0153, 16'h017E, 16'h0178
  };

  localparam logic [7:0] EXTRA_CODE [EXTRA_NUM] = '{
    8'h80, 8'h82, 8'h83, 8'h84, 8'h85, 8'h86, 8'h87,
    8'h88, 8'h89, 8'h8A, 8'h8B, 8'h8C, 8'h8E, 8'h91,
    8'h92, 8'h93, 8'h94, 8'h95, 8'h96, 8'h97, 8'h98,
    8'h99, 8'h9A, 8'h9B, 8'h9C, 8'h9E, 8'h9F
  };

endpackage

// File: design/u2c_map.sv
// Code point to Windows-1252 mapper: Latin-1 pass-through outside 0x80-0x9F, the 27 extras,
// '?' for the rest. Depends on u2c_pkg.
module u2c_map import u2c_pkg::*; (
  input  logic [CP_W-1:0] cp,
  output u2c_result_t     res
);

  logic       hit;
  logic [7:0] hit_code;

  always_comb begin
    hit      = 1'b0;
    hit_code = QMARK;
    for (int k = 0; k < EXTRA_NUM; k++) begin
      if (cp == {{(CP_W-16){1'b0}}, EXTRA_CP[k]}) begin
        hit      = 1'b1;
        hit_code = EXTRA_CODE[k];
      end
    end
  end

  always_comb begin
    if (cp[CP_W-1:8] == '0 && !(cp[7:5] == 3'b100)) begin
      res.code     = cp[7:0];
      res.replaced = 1'b0;
    end else if (hit) begin
      res.code     = hit_code;
      res.replaced = 1'b0;
    end else begin
      res.code     = QMARK;
      res.replaced = 1'b1;
    end
  end

endmodule

// File: design/utf8_to_cp1252_decoder.sv
// UTF-8 to Windows-1252 decoder. Takes one byte per cycle on the s_ side when
// s_tready is high and gives at most one item per byte on the m_ side, from the
// input register through the sequence state and mapper into the result register;
// a full stream runs at one byte per clock unless m_tready stalls the output.
// Multi-byte sequences emit on their final byte; a byte with s_tlast ends the
// string and resets the sequence state, giving '?' if it cut a sequence short.
// Depends on u2c_pkg, u2c_map and utf8_to_cp1252_decoder_assert.svh.
module utf8_to_cp1252_decoder import u2c_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,   // [7:0] in_byte
  input  logic       s_tlast,   // in_last
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata,   // [7:0] out_byte
  output logic       m_tuser,   // out_replaced
  output logic       m_tlast    // out_last
);

`include "utf8_to_cp1252_decoder_assert.svh"

  // input register
  logic       s1_valid;
  logic [7:0] s1_byte;
  logic       s1_last;

  // sequence state
  logic [1:0]      pending;
  logic [1:0]      pending_next;
  logic [CP_W-1:0] accum;
  logic [CP_W-1:0] accum_next;

  logic            done;
  logic            produce;
  logic            advance;
  logic [CP_W-1:0] cp;
  u2c_result_t     mapped;

  always_comb begin
    done         = 1'b0;
    cp           = {{(CP_W-8){1'b0}}, s1_byte};
    pending_next = pending;
    accum_next   = accum;
    if (pending == 2'd0) begin
      if (s1_byte >= LEAD4) begin
        accum_next   = {{(CP_W-3){1'b0}}, s1_byte[2:0]};
        pending_next = 2'd3;
      end else if (s1_byte >= LEAD3) begin
        accum_next   = {{(CP_W-4){1'b0}}, s1_byte[3:0]};
        pending_next = 2'd2;
      end else if (s1_byte >= LEAD2) begin
        accum_next   = {{(CP_W-5){1'b0}}, s1_byte[4:0]};
        pending_next = 2'd1;
      end else begin
        done = 1'b1;
      end
    end else begin
      accum_next   = {accum[CP_W-7:0], s1_byte[5:0]};
      pending_next = pending - 2'd1;
      cp           = accum_next;
      done         = (pending_next == 2'd0);
    end
    produce = done || s1_last;
    if (produce) begin
      pending_next = 2'd0;
      accum_next   = '0;
    end
  end

  u2c_map u_map (
    .cp  (cp),
    .res (mapped)
  );

  assign advance  = s1_valid && (!produce || !m_tvalid || m_tready);
  assign s_tready = !s1_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s_tready) begin
      s1_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready) begin
      s1_byte <= s_tdata;
      s1_last <= s_tlast;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= 2'd0;
      accum   <= '0;
    end else if (advance) begin
      pending <= pending_next;
      accum   <= accum_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance && produce) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && produce) begin
      m_tdata <= done ? mapped.code : QMARK;
      m_tuser <= done ? mapped.replaced : 1'b1;
      m_tlast <= s1_last;
    end
  end

  `U2C_ASSERT_NEXT(a_last_clears, advance && s1_last, pending == 2'd0 && accum == '0,
                   "state not cleared after end of string")
  `U2C_ASSERT_NOW(a_repl_qmark, m_tvalid && m_tuser, m_tdata == QMARK, "replaced item is not '?'")
  `U2C_ASSERT_NOW(a_accum_four, pending == 2'd3, accum[CP_W-1:3] == '0,
                  "accumulator too wide after 4-byte lead")
  `U2C_ASSERT_NOW(a_accum_last, pending == 2'd1, accum[CP_W-1:15] == '0,
                  "accumulator too wide before final byte")

endmodule

// File: tb/tb_top.sv
// Testbench for utf8_to_cp1252_decoder: drives UTF-8 strings with random gaps and
// stalls and checks each Windows-1252 item against its own decoder prediction.
// Depends on u2c_pkg and the decoder RTL.
module tb_top import u2c_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 400000;
  localparam int PHASE_BYTES = 365;
  localparam int DRAIN_CYCLES = 20;
  localparam int IDLE_PCT [4] = '{0, 79, 0, 27};
  localparam int STALL_PCT [4] = '{0, 0, 79, 27};

  // {in_last, in_byte}
  localparam logic [8:0] DIRECTED [22] = '{
    9'h000, 9'h07F, 9'h03F, 9'h080, 9'h0A0, 9'h1BF,
    9'h0C3, 9'h0A9, 9'h0C5, 9'h092,
    9'h0E2, 9'h082, 9'h1AC,
    9'h0C3, 9'h1BF,
    9'h0FF, 9'h080, 9'h080, 9'h180,
    9'h0E2, 9'h182,
    9'h1C3
  };

  typedef struct packed {
    u2c_result_t res;
    logic        last;
  } char_item_t;

  class decode_scoreboard;
    logic [1:0]    cont_left;
    logic [CP_W-1:0] code_point;
    char_item_t    expected_q[$];
    int            errors;

    function new();
      cont_left = '0;
      code_point = '0;
      errors = 0;
    endfunction

    function logic [7:0] to_cp1252(input logic [CP_W-1:0] cp, output logic replaced);
      logic [7:0] code;
      replaced = 1'b0;
      if (cp < 'h100 && (cp < 'h80 || cp > 'h9F)) return cp[7:0];
      case (cp)
        'h20AC: code = 8'h80;
        'h201A: code = 8'h82;
        'h0192: code = 8'h83;
        'h201E: code = 8'h84;
        'h2026: code = 8'h85;
        'h2020: code = 8'h86;
        'h2021: code = 8'h87;
        'h02C6: code = 8'h88;
        'h2030: code = 8'h89;
        'h0160: code = 8'h8A;
        'h2039: code = 8'h8B;
        'h0152: code = 8'h8C;
        'h017D: code = 8'h8E;
        'h2018: code = 8'h91;
        'h2019: code = 8'h92;
        'h201C: code = 8'h93;
        'h201D: code = 8'h94;
        'h2022: code = 8'h95;
        'h2013: code = 8'h96;
        'h2014: code = 8'h97;
        'h02DC: code = 8'h98;
        'h2122: code = 8'h99;
        'h0161: code = 8'h9A;
        'h203A: code = 8'h9B;
        'h0153: code = 8'h9C;
        'h017E: code = 8'h9E;
        'h0178: code = 8'h9F;
        default: begin
          code = QMARK;
          replaced = 1'b1;
        end
      endcase
      return code;
    endfunction

    function void note_byte(input logic [7:0] b, input logic last);
      logic done;
      logic [CP_W-1:0] cp;
      char_item_t item;
      done = 1'b0;
      cp = '0;
      if (cont_left == 0) begin
        if (b >= LEAD4) begin
          code_point = CP_W'(b[2:0]);
          cont_left = 2'd3;
        end else if (b >= LEAD3) begin
          code_point = CP_W'(b[3:0]);
          cont_left = 2'd2;
        end else if (b >= LEAD2) begin
          code_point = CP_W'(b[4:0]);
          cont_left = 2'd1;
        end else begin
          cp = CP_W'(b);
          done = 1'b1;
        end
      end else begin
        code_point = {code_point[CP_W-7:0], b[5:0]};
        cont_left = cont_left - 2'd1;
        if (cont_left == 0) begin
          cp = code_point;
          done = 1'b1;
        end
      end
      if (done) begin
        item.res.code = to_cp1252(cp, item.res.replaced);
      end else if (last) begin
        item.res.code = QMARK;
        item.res.replaced = 1'b1;
      end else begin
        return;
      end
      item.last = last;
      cont_left = '0;
      code_point = '0;
      expected_q.push_back(item);
    endfunction

    function void check_item(input logic [7:0] code, input logic replaced, input logic last);
      char_item_t exp_item;
      if (expected_q.size() == 0) begin
        $error("unexpected item: out_byte %h out_replaced %b out_last %b",
               code, replaced, last);
        errors++;
        return;
      end
      exp_item = expected_q.pop_front();
      if (code !== exp_item.res.code) begin
        $error("out_byte expected %h actual %h", exp_item.res.code, code);
        errors++;
      end
      if (replaced !== exp_item.res.replaced) begin
        $error("out_replaced expected %b actual %b", exp_item.res.replaced, replaced);
        errors++;
      end
      if (last !== exp_item.last) begin
        $error("out_last expected %b actual %b", exp_item.last, last);
        errors++;
      end
    endfunction
  endclass

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       s_tvalid = 1'b0;
  logic       s_tready;
  logic [7:0] s_tdata = '0;  // [7:0] in_byte
  logic       s_tlast = 1'b0;  // in_last
  logic       m_tvalid;
  logic       m_tready = 1'b0;
  logic [7:0] m_tdata;  // [7:0] out_byte
  logic       m_tuser;  // out_replaced
  logic       m_tlast;  // out_last

  decode_scoreboard sb = new();
  int idle_pct = 0;
  int stall_pct = 0;
  int bytes_sent = 0;
  int cycles = 0;

  utf8_to_cp1252_decoder i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    m_tready <= ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (s_tvalid && s_tready) sb.note_byte(s_tdata, s_tlast);
      if (m_tvalid && m_tready) sb.check_item(m_tdata, m_tuser, m_tlast);
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAIL utf8_to_cp1252_decoder");
      $finish;
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic last);
    while ($urandom_range(99) < idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= b;
    s_tlast <= last;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    bytes_sent++;
  endtask

  task automatic send_string();
    logic [7:0] str_q[$];
    logic [CP_W-1:0] cp;
    int nchars;
    int r;
    int idx;
    nchars = $urandom_range(1, 10);
    if ($urandom_range(99) < 15) begin
      // noise
      for (int i = 0; i < nchars; i++) str_q.push_back(8'($urandom()));
    end else begin
      for (int i = 0; i < nchars; i++) begin
        r = $urandom_range(99);
        if (r < 25) cp = CP_W'(EXTRA_CP[$urandom_range(EXTRA_NUM - 1)]);
        else if (r < 50) cp = CP_W'($urandom_range(0, 'h7F));
        else if (r < 62) cp = CP_W'($urandom_range('h80, 'hFF));
        else if (r < 75) cp = CP_W'($urandom_range('h100, 'h7FF));
        else if (r < 88) cp = CP_W'($urandom_range('h800, 'hFFFF));
        else cp = CP_W'($urandom_range('h10000, 'h1FFFFF));
        if (cp < 'h80) begin
          str_q.push_back(cp[7:0]);
        end else if (cp < 'h800) begin
          str_q.push_back({3'b110, cp[10:6]});
          str_q.push_back({2'b10, cp[5:0]});
        end else if (cp < 'h10000) begin
          str_q.push_back({4'b1110, cp[15:12]});
          str_q.push_back({2'b10, cp[11:6]});
          str_q.push_back({2'b10, cp[5:0]});
        end else begin
          str_q.push_back({5'b11110, cp[20:18]});
          str_q.push_back({2'b10, cp[17:12]});
          str_q.push_back({2'b10, cp[11:6]});
          str_q.push_back({2'b10, cp[5:0]});
        end
      end
      // one random byte of the string replaced by a random value
      if ($urandom_range(99) < 8) str_q[$urandom_range(str_q.size() - 1)] = 8'($urandom());
      // cut short, possibly mid-sequence
      if ($urandom_range(99) < 15) begin
        idx = $urandom_range(1, str_q.size());
        while (str_q.size() > idx) void'(str_q.pop_back());
      end
    end
    foreach (str_q[i]) send_byte(str_q[i], i == str_q.size() - 1);
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    for (int ph = 0; ph < 4; ph++) begin
      idle_pct = IDLE_PCT[ph];
      stall_pct = STALL_PCT[ph];
      if (ph == 0) begin
        foreach (DIRECTED[i]) send_byte(DIRECTED[i][7:0], DIRECTED[i][8]);
      end
      while (bytes_sent < (ph + 1) * PHASE_BYTES) send_string();
    end
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.expected_q.size() == 0) begin
      $display("PASS utf8_to_cp1252_decoder");
    end else begin
      $display("FAIL utf8_to_cp1252_decoder");
    end
    $finish;
  end

endmodule

// File: filelist.f
+incdir+design
design/u2c_pkg.sv
design/u2c_map.sv
design/utf8_to_cp1252_decoder.sv
tb/tb_top.sv
